// ===== design/kci_pkg.sv =====
// Shared constants, keyframe tables and pipeline geometry for the keyframe color interpolator.
package kci_pkg;

  localparam int SLOT_COUNT      = 16;
  localparam int IDX_W           = $clog2(SLOT_COUNT);
  localparam int KEYFRAME_COUNT  = 7;
  localparam int TIME_W          = 16;
  localparam int CHAN_W          = 8;
  localparam int RGB_W           = 3 * CHAN_W;
  localparam int QUOT_W          = 8;
  localparam int SEARCH_STAGES   = 1;
  localparam int MIX_STAGES      = 3;
  localparam int PIPE_STAGES     = SEARCH_STAGES + QUOT_W + MIX_STAGES;

  localparam logic [TIME_W-1:0] T_0000 = 16'd0;
  localparam logic [TIME_W-1:0] T_0500 = 16'd13653;
  localparam logic [TIME_W-1:0] T_0540 = 16'd15473;
  localparam logic [TIME_W-1:0] T_0600 = 16'd16384;
  localparam logic [TIME_W-1:0] T_0700 = 16'd19114;
  localparam logic [TIME_W-1:0] T_1700 = 16'd46421;
  localparam logic [TIME_W-1:0] T_1740 = 16'd48241;
  localparam logic [TIME_W-1:0] T_1800 = 16'd49152;
  localparam logic [TIME_W-1:0] T_1820 = 16'd50062;
  localparam logic [TIME_W-1:0] T_1900 = 16'd51882;

  function automatic logic [TIME_W-1:0] kf_time(input logic moon, input logic [IDX_W-1:0] idx);
    logic [TIME_W-1:0] t;
    if (moon) begin
      case (idx)
        4'd0:    t = T_0000;
        4'd1:    t = T_0500;
        4'd2:    t = T_0540;
        4'd3:    t = T_0600;
        4'd4:    t = T_1740;
        4'd5:    t = T_1800;
        default: t = T_1900;
      endcase
    end else begin
      case (idx)
        4'd0:    t = T_0000;
        4'd1:    t = T_0540;
        4'd2:    t = T_0600;
        4'd3:    t = T_0700;
        4'd4:    t = T_1700;
        4'd5:    t = T_1800;
        default: t = T_1820;
      endcase
    end
    return t;
  endfunction

  function automatic logic [RGB_W-1:0] kf_rgb(input logic moon, input logic [IDX_W-1:0] idx);
    logic [RGB_W-1:0] c;
    if (moon) begin
      case (idx)
        4'd0:    c = 24'h606870;
        4'd1:    c = 24'h606870;
        4'd2:    c = 24'h404448;
        4'd3:    c = 24'h000000;
        4'd4:    c = 24'h000000;
        4'd5:    c = 24'h404448;
        default: c = 24'h606870;
      endcase
    end else begin
      case (idx)
        4'd0:    c = 24'h000000;
        4'd1:    c = 24'h000000;
        4'd2:    c = 24'hE08080;
        4'd3:    c = 24'hFFF0E0;
        4'd4:    c = 24'hFFF0E0;
        4'd5:    c = 24'hFFE0B0;
        default: c = 24'h000000;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== design/kci_seg_search.sv =====
// Segment search stage: pick the keyframe segment, register elapsed time, span and end colors.
module kci_seg_search #(
  parameter int KEYFRAME_COUNT = kci_pkg::KEYFRAME_COUNT
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [kci_pkg::TIME_W-1:0]   time_of_day_i,
  input  logic                         use_moon_table_i,
  output logic [kci_pkg::TIME_W-1:0]   elapsed_o,
  output logic [kci_pkg::TIME_W-1:0]   span_o,
  output logic [2*kci_pkg::RGB_W-1:0]  colors_o
);
  import kci_pkg::*;

  localparam int CNT = (KEYFRAME_COUNT > SLOT_COUNT) ? SLOT_COUNT :
                       (KEYFRAME_COUNT < 1) ? 1 : KEYFRAME_COUNT;

  logic [CNT-1:0]     hit;
  logic               found;
  logic [IDX_W-1:0]   seg;
  logic [TIME_W-1:0]  a_t;
  logic [TIME_W-1:0]  b_t;
  logic [RGB_W-1:0]   a_c;
  logic [RGB_W-1:0]   b_c;
  logic [RGB_W-1:0]   last_c;
  logic [TIME_W-1:0]  elapsed_d, elapsed_q;
  logic [TIME_W-1:0]  span_d, span_q;
  logic [2*RGB_W-1:0] colors_d, colors_q;

  always_comb begin
    hit = '0;
    for (int i = 0; i + 1 < CNT; i++) begin
      hit[i] = (time_of_day_i < kf_time(use_moon_table_i, IDX_W'(i + 1))) &&
               (kf_time(use_moon_table_i, IDX_W'(i + 1)) >
                kf_time(use_moon_table_i, IDX_W'(i)));
    end
  end

  always_comb begin
    found = 1'b0;
    seg   = '0;
    for (int i = CNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        seg   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    a_t    = kf_time(use_moon_table_i, seg);
    b_t    = kf_time(use_moon_table_i, seg + IDX_W'(1));
    a_c    = kf_rgb(use_moon_table_i, seg);
    b_c    = kf_rgb(use_moon_table_i, seg + IDX_W'(1));
    last_c = kf_rgb(use_moon_table_i, IDX_W'(CNT - 1));
    if (found) begin
      elapsed_d = (time_of_day_i >= a_t) ? (time_of_day_i - a_t) : '0;
      span_d    = b_t - a_t;
      colors_d  = {a_c, b_c};
    end else begin
      elapsed_d = '0;
      span_d    = TIME_W'(1);
      colors_d  = {last_c, last_c};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elapsed_q <= elapsed_d;
      span_q    <= span_d;
      colors_q  <= colors_d;
    end
  end

  assign elapsed_o = elapsed_q;
  assign span_o    = span_q;
  assign colors_o  = colors_q;

endmodule

// ===== design/kci_divider.sv =====
// Pipelined restoring divider: blend factor = elapsed * 255 / span, one quotient bit per stage.
module kci_divider #(
  parameter int SIDE_W = 2 * kci_pkg::RGB_W
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [kci_pkg::TIME_W-1:0]  elapsed_i,
  input  logic [kci_pkg::TIME_W-1:0]  span_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [kci_pkg::QUOT_W-1:0]  quot_o,
  output logic [SIDE_W-1:0]           side_o
);
  import kci_pkg::*;

  localparam int NUM_W = TIME_W + QUOT_W;

  logic [TIME_W-1:0] rem_q  [QUOT_W];
  logic [QUOT_W-1:0] low_q  [QUOT_W];
  logic [QUOT_W-1:0] quot_q [QUOT_W];
  logic [TIME_W-1:0] span_q [QUOT_W];
  logic [SIDE_W-1:0] side_q [QUOT_W];

  logic [NUM_W-1:0] num;
  assign num = {elapsed_i, QUOT_W'(0)} - {QUOT_W'(0), elapsed_i};

  for (genvar s = 0; s < QUOT_W; s++) begin : g_step
    logic [TIME_W-1:0] rem_in;
    logic [QUOT_W-1:0] low_in;
    logic [QUOT_W-1:0] quot_in;
    logic [TIME_W-1:0] span_in;
    logic [SIDE_W-1:0] side_in;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = num[NUM_W-1:QUOT_W];
      assign low_in  = num[QUOT_W-1:0];
      assign quot_in = '0;
      assign span_in = span_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign quot_in = quot_q[s-1];
      assign span_in = span_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, low_in[QUOT_W-1]};
    assign diff  = trial - {1'b0, span_in};
    assign ge    = (trial >= {1'b0, span_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        low_q[s]  <= {low_in[QUOT_W-2:0], 1'b0};
        quot_q[s] <= {quot_in[QUOT_W-2:0], ge};
        span_q[s] <= span_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = quot_q[QUOT_W-1];
  assign side_o = side_q[QUOT_W-1];

endmodule

// ===== design/kci_mix.sv =====
// Channel blend pipeline: start + trunc((end - start) * factor / 255), clamped to 0..255.
module kci_mix (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [kci_pkg::CHAN_W-1:0]  from_i,
  input  logic [kci_pkg::CHAN_W-1:0]  to_i,
  input  logic [kci_pkg::QUOT_W-1:0]  weight_i,
  output logic [kci_pkg::CHAN_W-1:0]  channel_o
);
  import kci_pkg::*;

  logic signed [CHAN_W:0]     delta;
  logic signed [2*CHAN_W+1:0] prod_d, prod_q;
  logic [CHAN_W-1:0]          from1_q, from2_q;
  logic [2*CHAN_W+1:0]        mag;
  logic [15:0]                x;
  logic [16:0]                sum;
  logic [8:0]                 q0;
  logic [16:0]                q0x255;
  logic [16:0]                rem;
  logic [8:0]                 q1;
  logic [CHAN_W-1:0]          quot_d, quot_q;
  logic                       neg_q;
  logic signed [CHAN_W+1:0]   v;
  logic [CHAN_W-1:0]          chan_d, chan_q;

  assign delta  = $signed({1'b0, to_i}) - $signed({1'b0, from_i});
  assign prod_d = delta * $signed({1'b0, weight_i});

  always_comb begin
    mag    = prod_q[2*CHAN_W+1] ? 18'(-prod_q) : 18'(prod_q);
    x      = mag[15:0];
    sum    = {1'b0, x} + {9'b0, x[15:8]};
    q0     = sum[16:8];
    q0x255 = {q0, 8'b0} - {8'b0, q0};
    rem    = {1'b0, x} - q0x255;
    q1     = (rem >= 17'd255) ? (q0 + 9'd1) : q0;
    quot_d = q1[CHAN_W-1:0];
  end

  always_comb begin
    v = neg_q ? ($signed({2'b0, from2_q}) - $signed({2'b0, quot_q}))
              : ($signed({2'b0, from2_q}) + $signed({2'b0, quot_q}));
    if (v < 0) begin
      chan_d = '0;
    end else if (v > 10'sd255) begin
      chan_d = '1;
    end else begin
      chan_d = v[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      from1_q <= from_i;
      quot_q  <= quot_d;
      neg_q   <= prod_q[2*CHAN_W+1];
      from2_q <= from1_q;
      chan_q  <= chan_d;
    end
  end

  assign channel_o = chan_q;

endmodule

// ===== design/keyframe_color_interpolator_core.sv =====
// Top level of the keyframe color interpolator: search, divide and blend pipeline.
//
//   channel | direction | handshake                | payload
//   input   | in        | in_valid_i / in_ready_o  | time_of_day_i, use_moon_table_i
//   output  | out       | out_valid_o / out_ready_i| red_o, green_o, blue_o
//
// One word per cycle while the output is not stalled; the pipeline has one search stage,
// eight divider stages (one quotient bit each) and three blend stages.
// Reset clears only the stage valid bits; the datapath carries no reset.
// A stall at the output freezes the whole pipeline; in_ready_o drops only while
// the last stage holds a word that is not taken.
module keyframe_color_interpolator_core #(
  parameter int KEYFRAME_COUNT = kci_pkg::KEYFRAME_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kci_pkg::TIME_W-1:0]  time_of_day_i,
  input  logic                        use_moon_table_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kci_pkg::CHAN_W-1:0]  red_o,
  output logic [kci_pkg::CHAN_W-1:0]  green_o,
  output logic [kci_pkg::CHAN_W-1:0]  blue_o
);
  import kci_pkg::*;

  logic                   en;
  logic [PIPE_STAGES-1:0] valid_d, valid_q;
  logic [TIME_W-1:0]      elapsed;
  logic [TIME_W-1:0]      span;
  logic [2*RGB_W-1:0]     colors_s;
  logic [2*RGB_W-1:0]     colors_d;
  logic [QUOT_W-1:0]      weight;

  assign en         = !valid_q[PIPE_STAGES-1] || out_ready_i;
  assign in_ready_o = en;
  assign valid_d    = {valid_q[PIPE_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  kci_seg_search #(
    .KEYFRAME_COUNT(KEYFRAME_COUNT)
  ) u_search (
    .clk_i           (clk_i),
    .en_i            (en),
    .time_of_day_i   (time_of_day_i),
    .use_moon_table_i(use_moon_table_i),
    .elapsed_o       (elapsed),
    .span_o          (span),
    .colors_o        (colors_s)
  );

  kci_divider #(
    .SIDE_W(2 * RGB_W)
  ) u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .elapsed_i(elapsed),
    .span_i   (span),
    .side_i   (colors_s),
    .quot_o   (weight),
    .side_o   (colors_d)
  );

  kci_mix u_mix_r (
    .clk_i    (clk_i),
    .en_i     (en),
    .from_i   (colors_d[2*RGB_W-1 -: CHAN_W]),
    .to_i     (colors_d[RGB_W-1 -: CHAN_W]),
    .weight_i (weight),
    .channel_o(red_o)
  );

  kci_mix u_mix_g (
    .clk_i    (clk_i),
    .en_i     (en),
    .from_i   (colors_d[2*RGB_W-CHAN_W-1 -: CHAN_W]),
    .to_i     (colors_d[RGB_W-CHAN_W-1 -: CHAN_W]),
    .weight_i (weight),
    .channel_o(green_o)
  );

  kci_mix u_mix_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .from_i   (colors_d[RGB_W+CHAN_W-1 -: CHAN_W]),
    .to_i     (colors_d[CHAN_W-1:0]),
    .weight_i (weight),
    .channel_o(blue_o)
  );

  assign out_valid_o = valid_q[PIPE_STAGES-1];

endmodule
